### sv/assert_macros.svh
// Assertion macros for the deque engine checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CDE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque engine check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CDE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque engine check failed");

`endif

### sv/cde_pkg.sv
// Shared constants and codes for the circular deque engine.
`timescale 1ns / 1ps
package cde_pkg;

	localparam int DEF_DEPTH     = 1024;
	localparam int DEF_WORD_BITS = 32;

	localparam int KIND_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 10;
	localparam int CAP_W    = 11;
	localparam int STATUS_W = 2;

	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = KIND_W;
	localparam int M_TDATA_W = 48;
	localparam int M_TUSER_W = STATUS_W;
	localparam int M_PAD_W   = M_TDATA_W - VALUE_W - CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SET        = 3'd4;
	localparam logic [KIND_W-1:0] KIND_GET        = 3'd5;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

### sv/circular_deque_engine_core.sv
// Circular deque engine: ring store in RAM with head pointer and element count.
// Throughput: one request per cycle while the output is not stalled; head and count update at the accept edge.
// Result path: the RAM read and the stage-1 register, then the output register.
// The output register decouples stalls.
// Reset: head and count go to zero, capacity to 1024; ring contents undefined.
`timescale 1ns / 1ps
module circular_deque_engine_core #(
	parameter int DEPTH     = cde_pkg::DEF_DEPTH,
	parameter int WORD_BITS = cde_pkg::DEF_WORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [cde_pkg::S_TDATA_W-1:0] s_tdata,  // value[31:0], index[41:32]
	input  logic [cde_pkg::S_TUSER_W-1:0] s_tuser,  // kind[2:0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [cde_pkg::M_TDATA_W-1:0] m_tdata,  // read_value[31:0], count[42:32]
	output logic [cde_pkg::M_TUSER_W-1:0] m_tuser,  // status[1:0]
	input  logic                         cfg_we,
	input  logic [cde_pkg::CAP_W-1:0]     cfg_data
);
	import cde_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = ((AW > CAP_W) ? AW : CAP_W) + 1;

	function automatic logic [SW-1:0] wrap_slot(input logic [SW-1:0] p, input logic [SW-1:0] c);
		return (p >= c) ? p - c : p;
	endfunction

	logic [CAP_W-1:0] cap_q;
	logic [AW-1:0]    head_q;
	logic [CAP_W-1:0] cnt_q;

	logic [KIND_W-1:0]  in_kind;
	logic [VALUE_W-1:0] in_value;
	logic [INDEX_W-1:0] in_index;

	logic [SW-1:0] cap_raw, cap_sw, head_sw, cnt_sw, idx_sw;
	logic [SW-1:0] pos_pb, pos_bb, pos_pf, pos_nf, pos_ix;
	logic          is_full, is_empty, out_range;

	logic                op_we, op_re;
	logic [AW-1:0]       op_addr;
	logic [STATUS_W-1:0] op_status;
	logic [AW-1:0]       head_d;
	logic [CAP_W-1:0]    cnt_d;

	logic accept, out_free, s1_adv;
	logic [63:0]          value_ext, rd_ext;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

	logic                valid_s1, rd_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [CAP_W-1:0]    count_s1;

	logic                m_tvalid_q;
	logic [VALUE_W-1:0]  m_value_q;
	logic [STATUS_W-1:0] m_status_q;
	logic [CAP_W-1:0]    m_count_q;

	assign in_kind  = s_tuser[KIND_W-1:0];
	assign in_value = s_tdata[VALUE_W-1:0];
	assign in_index = s_tdata[VALUE_W+INDEX_W-1:VALUE_W];

	always_comb begin
		cap_raw   = (cap_q == '0) ? SW'(1) : SW'(cap_q);
		cap_sw    = (cap_raw > SW'(DEPTH)) ? SW'(DEPTH) : cap_raw;
		head_sw   = SW'(head_q);
		cnt_sw    = SW'(cnt_q);
		idx_sw    = SW'(in_index);
		pos_pb    = wrap_slot(head_sw + cnt_sw, cap_sw);
		pos_bb    = wrap_slot(head_sw + cnt_sw - SW'(1), cap_sw);
		pos_pf    = (head_q == '0) ? cap_sw - SW'(1) : head_sw - SW'(1);
		pos_nf    = wrap_slot(head_sw + SW'(1), cap_sw);
		pos_ix    = wrap_slot(head_sw + idx_sw, cap_sw);
		is_full   = cnt_sw >= cap_sw;
		is_empty  = cnt_q == '0;
		out_range = idx_sw >= cnt_sw;
	end

	always_comb begin
		op_we     = 1'b0;
		op_re     = 1'b0;
		op_addr   = pos_ix[AW-1:0];
		op_status = ST_DONE;
		head_d    = head_q;
		cnt_d     = cnt_q;
		case (in_kind)
			KIND_PUSH_BACK: begin
				if (is_full) begin
					op_status = ST_FULL;
				end else begin
					op_we   = 1'b1;
					op_addr = pos_pb[AW-1:0];
					cnt_d   = cnt_q + CAP_W'(1);
				end
			end
			KIND_POP_BACK: begin
				if (is_empty) begin
					op_status = ST_EMPTY;
				end else begin
					op_re   = 1'b1;
					op_addr = pos_bb[AW-1:0];
					cnt_d   = cnt_q - CAP_W'(1);
				end
			end
			KIND_PUSH_FRONT: begin
				if (is_full) begin
					op_status = ST_FULL;
				end else begin
					op_we   = 1'b1;
					op_addr = pos_pf[AW-1:0];
					head_d  = pos_pf[AW-1:0];
					cnt_d   = cnt_q + CAP_W'(1);
				end
			end
			KIND_POP_FRONT: begin
				if (is_empty) begin
					op_status = ST_EMPTY;
				end else begin
					op_re   = 1'b1;
					op_addr = head_q;
					head_d  = pos_nf[AW-1:0];
					cnt_d   = cnt_q - CAP_W'(1);
				end
			end
			KIND_SET: begin
				if (out_range) begin
					op_status = ST_RANGE;
				end else begin
					op_we = 1'b1;
				end
			end
			KIND_GET: begin
				if (out_range) begin
					op_status = ST_RANGE;
				end else begin
					op_re = 1'b1;
				end
			end
			default: begin
				op_status = ST_RANGE;
			end
		endcase
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign s1_adv   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	assign value_ext = 64'(in_value);
	assign ram_wdata = value_ext[WORD_BITS-1:0];
	assign rd_ext    = 64'(ram_rdata);

	cde_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ring (
		.clk  (clk),
		.we   (accept && op_we),
		.re   (accept && op_re),
		.addr (op_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			head_q <= '0;
			cnt_q  <= '0;
		end else if (cfg_we) begin
			cap_q  <= cfg_data;
			head_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			head_q <= head_d;
			cnt_q  <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= op_re;
			status_s1 <= op_status;
			count_s1  <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s1_adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			m_value_q  <= rd_s1 ? rd_ext[VALUE_W-1:0] : '0;
			m_status_q <= status_s1;
			m_count_q  <= count_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, m_count_q, m_value_q};
	assign m_tuser  = m_status_q;

endmodule

### sv/cde_ram.sv
// Single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module cde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

### sv/cde_checker.sv
// Port-level checks for the circular deque engine, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cde_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [cde_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [cde_pkg::M_TUSER_W-1:0] m_tuser
);
	import cde_pkg::*;

	logic [VALUE_W-1:0] chk_value;
	logic [CAP_W-1:0]   chk_count;
	logic               stalled;

	assign chk_value = m_tdata[VALUE_W-1:0];
	assign chk_count = m_tdata[VALUE_W+CAP_W-1:VALUE_W];
	assign stalled   = m_tvalid && !m_tready;

	`CDE_ASSERT_NEXT(a_hold_result, stalled, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`CDE_ASSERT_NOW(a_refused_zero, m_tvalid && (m_tuser != ST_DONE), chk_value == '0)
	`CDE_ASSERT_NOW(a_empty_count, m_tvalid && (m_tuser == ST_EMPTY), chk_count == '0)
	`CDE_ASSERT_NOW(a_full_count, m_tvalid && (m_tuser == ST_FULL), chk_count != '0)

endmodule

bind circular_deque_engine_core cde_checker u_cde_checker (.*);

### test/testbench.sv
// Self-checking testbench for circular_deque_engine_core: random and directed deque requests.
`timescale 1ns / 1ps
module testbench;
	import cde_pkg::*;

	localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;
	localparam int MAX_WAIT      = 12;
	localparam int SETTLE_CYCLES = 6;
	localparam int QUIET_LIMIT   = 300;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] index;
	} deque_req_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  word;
		logic [STATUS_W-1:0] status;
		logic [CAP_W-1:0]    count;
	} deque_rsp_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 cfg_we = 1'b0;
	logic [CAP_W-1:0]     cfg_data = CAP_RESET;

	circular_deque_engine_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// deque copy
	logic [VALUE_W-1:0] ring_copy [0:DEF_DEPTH-1];
	int unsigned        head_copy = 0;
	int unsigned        held_copy = 0;
	logic [CAP_W-1:0]   cap_copy = CAP_RESET;

	deque_req_t  queued_reqs [$];
	deque_rsp_t  owed_results [$];
	int unsigned issued = 0;
	int unsigned accepted = 0;
	int unsigned gen_held = 0;
	int          failures = 0;
	int          quiet_cycles = 0;

	logic        req_taken = 1'b0;
	logic        rsp_taken = 1'b0;
	int unsigned send_wait = 0;
	int unsigned rsp_wait = 0;
	logic        send_burst = 1'b0;
	logic        recv_burst = 1'b0;

	function automatic int unsigned ring_slots();
		int unsigned c;
		c = cap_copy;
		if (c == 0)
			c = 1;
		if (c > DEF_DEPTH)
			c = DEF_DEPTH;
		return c;
	endfunction

	function automatic int unsigned slot_at(input int unsigned off, input int unsigned cap);
		int unsigned p;
		p = head_copy + off;
		if (p >= cap)
			p = p - cap;
		return p;
	endfunction

	task automatic predict_deque_op(input deque_req_t r, output deque_rsp_t res);
		int unsigned cap;
		int unsigned slot;
		cap = ring_slots();
		res.word = '0;
		res.status = ST_DONE;
		case (r.kind)
		KIND_PUSH_BACK: begin
			if (held_copy >= cap) begin
				res.status = ST_FULL;
			end else begin
				ring_copy[slot_at(held_copy, cap)] = r.value;
				held_copy++;
			end
		end
		KIND_POP_BACK: begin
			if (held_copy == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.word = ring_copy[slot_at(held_copy - 1, cap)];
				held_copy--;
			end
		end
		KIND_PUSH_FRONT: begin
			if (held_copy >= cap) begin
				res.status = ST_FULL;
			end else begin
				slot = (head_copy == 0) ? cap - 1 : head_copy - 1;
				ring_copy[slot] = r.value;
				head_copy = slot;
				held_copy++;
			end
		end
		KIND_POP_FRONT: begin
			if (held_copy == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.word = ring_copy[head_copy];
				head_copy = slot_at(1, cap);
				held_copy--;
			end
		end
		KIND_SET: begin
			if (r.index >= held_copy) begin
				res.status = ST_RANGE;
			end else begin
				ring_copy[slot_at(r.index, cap)] = r.value;
			end
		end
		KIND_GET: begin
			if (r.index >= held_copy) begin
				res.status = ST_RANGE;
			end else begin
				res.word = ring_copy[slot_at(r.index, cap)];
			end
		end
		default: begin
			res.status = ST_RANGE;
		end
		endcase
		res.count = CAP_W'(held_copy);
	endtask

	// request driver
	always @(negedge clk) begin
		deque_req_t r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_taken) begin
			if (send_wait != 0) begin
				s_tvalid <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (queued_reqs.size() != 0) begin
				r = queued_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {{(S_TDATA_W - INDEX_W - VALUE_W){1'b0}}, r.index, r.value};
				s_tuser <= r.kind;
				send_wait <= send_burst ? 0 : $urandom_range(0, MAX_WAIT);
				if ($urandom_range(0, 31) == 0)
					send_burst <= !send_burst;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result backpressure
	always @(negedge clk) begin
		int unsigned stall;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rsp_taken) begin
			stall = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
			m_tready <= (stall == 0);
			rsp_wait <= stall;
			if ($urandom_range(0, 31) == 0)
				recv_burst <= !recv_burst;
		end else if (!m_tready) begin
			if (rsp_wait == 0)
				m_tready <= 1'b1;
			else if (m_tvalid)
				rsp_wait <= rsp_wait - 1;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		deque_rsp_t got;
		deque_rsp_t want;
		deque_req_t r;
		req_taken <= arst_n && s_tvalid && s_tready;
		rsp_taken <= arst_n && m_tvalid && m_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.word = m_tdata[VALUE_W-1:0];
				got.status = m_tuser;
				got.count = m_tdata[VALUE_W +: CAP_W];
				if (owed_results.size() == 0) begin
					$display("%0t: unexpected result: word %h status %0d count %0d",
						$time, got.word, got.status, got.count);
					failures++;
				end else begin
					want = owed_results.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
							$time, want.word, want.status, want.count,
							got.word, got.status, got.count);
						failures++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				r.kind = s_tuser;
				r.value = s_tdata[VALUE_W-1:0];
				r.index = s_tdata[VALUE_W +: INDEX_W];
				predict_deque_op(r, want);
				owed_results.push_back(want);
				accepted++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("circular_deque_engine_core regression: fail");
		$finish;
	end

	task automatic add_req(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v,
			input logic [INDEX_W-1:0] i);
		deque_req_t r;
		r.kind = k;
		r.value = v;
		r.index = i;
		case (k)
		KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
			if (gen_held < ring_slots())
				gen_held++;
		end
		KIND_POP_BACK, KIND_POP_FRONT: begin
			if (gen_held != 0)
				gen_held--;
		end
		default: ;
		endcase
		queued_reqs.push_back(r);
		issued++;
	endtask

	function automatic logic [VALUE_W-1:0] rand_word();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return $urandom();
	endfunction

	function automatic logic [INDEX_W-1:0] rand_index();
		if (gen_held != 0 && $urandom_range(0, 3) != 0)
			return INDEX_W'($urandom_range(0, gen_held - 1));
		if ($urandom_range(0, 1) == 0)
			return INDEX_W'(gen_held);
		return INDEX_W'($urandom_range(0, DEF_DEPTH - 1));
	endfunction

	task automatic random_mix(input int n, input int unsigned push_pct,
			input int unsigned pop_pct);
		int unsigned roll;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < push_pct)
				add_req($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
					rand_word(), rand_index());
			else if (roll < push_pct + pop_pct)
				add_req($urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT,
					rand_word(), rand_index());
			else if (roll < 98)
				add_req($urandom_range(0, 1) ? KIND_SET : KIND_GET,
					rand_word(), rand_index());
			else
				add_req($urandom_range(0, 1) ? KIND_RSVD_LO : KIND_RSVD_HI,
					rand_word(), rand_index());
		end
	endtask

	task automatic drain_and_settle();
		while (accepted != issued || owed_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		drain_and_settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cap_copy = v;
		head_copy = 0;
		held_copy = 0;
		gen_held = 0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_req(KIND_POP_BACK, 32'h0, 10'd0);
		add_req(KIND_POP_FRONT, '1, 10'd0);
		add_req(KIND_GET, 32'h0, 10'd0);
		add_req(KIND_SET, '1, '1);
		add_req(KIND_PUSH_BACK, 32'h0, 10'd0);
		add_req(KIND_PUSH_BACK, '1, '1);
		add_req(KIND_PUSH_FRONT, 32'h1234_5678, 10'd0);
		add_req(KIND_PUSH_FRONT, 32'hA5A5_A5A5, 10'd0);
		add_req(KIND_GET, 32'h0, 10'd0);
		add_req(KIND_GET, 32'h0, 10'd3);
		add_req(KIND_SET, 32'h5A5A_5A5A, 10'd1);
		add_req(KIND_GET, 32'h0, 10'd1);
		add_req(KIND_GET, 32'h0, 10'd4);
		add_req(KIND_GET, 32'h0, '1);
		add_req(KIND_RSVD_LO, '1, '1);
		add_req(KIND_RSVD_HI, 32'h0, 10'd0);
		add_req(KIND_POP_BACK, 32'h0, 10'd0);
		add_req(KIND_POP_FRONT, 32'h0, 10'd0);
		add_req(KIND_POP_BACK, 32'h0, 10'd0);
		add_req(KIND_POP_FRONT, 32'h0, 10'd0);
		add_req(KIND_POP_FRONT, 32'h0, 10'd0);

		write_capacity(11'd1);
		add_req(KIND_PUSH_FRONT, 32'hC0FF_EE00, 10'd0);
		add_req(KIND_PUSH_BACK, 32'h0BAD_F00D, 10'd0);
		add_req(KIND_GET, 32'h0, 10'd0);
		add_req(KIND_POP_BACK, 32'h0, 10'd0);
		add_req(KIND_POP_FRONT, 32'h0, 10'd0);

		write_capacity(11'd0);
		random_mix(40, 45, 35);
		for (int p = 0; p < 10; p++) begin
			write_capacity(CAP_W'($urandom_range(1, 40)));
			random_mix(32, $urandom_range(25, 60), 30);
		end

		write_capacity(11'd2047);
		while (gen_held < ring_slots())
			random_mix(1, 90, 0);
		random_mix(30, 50, 0);
		random_mix(60, 15, 55);

		write_capacity(CAP_RESET);
		random_mix(40, 45, 35);

		drain_and_settle();
		if (failures == 0 && owed_results.size() == 0)
			$display("circular_deque_engine_core regression: pass");
		else
			$display("circular_deque_engine_core regression: fail");
		$finish;
	end

endmodule
